[rtl/u8sd_pkg.sv]
// ----------------------------------------------------------------------------
// u8sd_pkg
// Shared types, constants and lookup functions for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package u8sd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CodeW = 32;
  localparam int unsigned CntW  = 3;

  localparam logic [CodeW-1:0] ReplResetVal = 32'h0000_003F;

  // Decoder state carried from one byte to the next.
  typedef struct packed {
    logic [CntW-1:0]  remaining;
    logic [CntW-1:0]  extra;
    logic [CodeW-1:0] acc;
  } seq_state_t;

  // One result word as produced by the step logic.
  typedef struct packed {
    logic             valid;
    logic [CodeW-1:0] code;
    logic             replaced;
    logic             eot;
  } result_t;

  // Trailing byte count implied by a lead byte.
  function automatic logic [CntW-1:0] lead_count(input logic [ByteW-1:0] b);
    logic [CntW-1:0] n;
    if (b < 8'hC0) begin
      n = 3'd0;
    end else if (b < 8'hE0) begin
      n = 3'd1;
    end else if (b < 8'hF0) begin
      n = 3'd2;
    end else if (b < 8'hF8) begin
      n = 3'd3;
    end else if (b < 8'hFC) begin
      n = 3'd4;
    end else begin
      n = 3'd5;
    end
    return n;
  endfunction

  // Offset removed from the accumulator once a sequence of this length ends.
  function automatic logic [CodeW-1:0] seq_offset(input logic [CntW-1:0] n);
    logic [CodeW-1:0] v;
    case (n)
      3'd1:    v = 32'h0000_3080;
      3'd2:    v = 32'h000E_2080;
      3'd3:    v = 32'h03C8_2080;
      3'd4:    v = 32'hFA08_2080;
      3'd5:    v = 32'h8208_2080;
      default: v = 32'h0000_0000;
    endcase
    return v;
  endfunction

endpackage

[rtl/utf8_stream_decoder.sv]
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Streaming UTF-8 decoder: one byte per word in, at most one code point out.
// ----------------------------------------------------------------------------
// A code point appears at the output in the cycle after the byte that
// completes it is accepted. Throughput: one byte per cycle unless the
// output stalls, set by the single state update (shift, add) per byte.
// Reset: sequence state and output valid clear, replacement code returns to
// 0x3F ('?'); no clearing pass is needed.
// ----------------------------------------------------------------------------
module utf8_stream_decoder (
  input  logic                       clk_i,
  input  logic                       rst_ni,

  // Configuration write channel: replacement code point.
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [u8sd_pkg::CodeW-1:0] cfg_data_i,

  // Byte input channel.
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [u8sd_pkg::ByteW-1:0] text_byte_i,
  input  logic                       last_byte_i,

  // Code point output channel.
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [u8sd_pkg::CodeW-1:0] code_point_o,
  output logic                       replaced_o,
  output logic                       end_of_text_o
);

  // Sequence state: trailing bytes still expected, length of the sequence
  // and the partial accumulator.
  u8sd_pkg::seq_state_t state_q, state_d;
  u8sd_pkg::result_t    step_res;

  logic [u8sd_pkg::CodeW-1:0] repl_q;

  // Output register. A new byte is taken whenever this register is empty or
  // is being drained in the same cycle, so the stream never stalls on its own.
  logic                       out_valid_q, out_valid_d;
  logic [u8sd_pkg::CodeW-1:0] code_q;
  logic                       replaced_q;
  logic                       eot_q;

  logic in_fire;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;

  u8sd_step u_step (
    .state_i     (state_q),
    .text_byte_i (text_byte_i),
    .last_byte_i (last_byte_i),
    .repl_i      (repl_q),
    .state_o     (state_d),
    .result_o    (step_res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire) begin
      out_valid_d = step_res.valid;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
      repl_q      <= u8sd_pkg::ReplResetVal;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_fire) begin
        state_q <= state_d;
      end
      if (cfg_valid_i) begin
        repl_q <= cfg_data_i;
      end
    end
  end

  // Payload of the output register; it only loads with a fresh result.
  always_ff @(posedge clk_i) begin
    if (in_fire && step_res.valid) begin
      code_q     <= step_res.code;
      replaced_q <= step_res.replaced;
      eot_q      <= step_res.eot;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign code_point_o  = code_q;
  assign replaced_o    = replaced_q;
  assign end_of_text_o = eot_q;

`ifndef NO_ASSERTIONS
  // The count of bytes still expected never exceeds the sequence length.
  a_remaining_le_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.remaining <= state_q.extra)
    else $error("remaining count exceeds sequence length");

  // The final byte of a text always yields a result and clears the state.
  a_last_flushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && last_byte_i |=> out_valid_q && eot_q && state_q.remaining == '0)
    else $error("final byte did not flush the sequence");

  // A replacement is only ever produced at the end of a text.
  a_repl_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && replaced_q |-> eot_q)
    else $error("replacement outside end of text");

  // A single-byte lead outside a sequence is emitted directly.
  a_ascii_direct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && state_q.remaining == '0 && text_byte_i < 8'hC0
    |=> out_valid_q && !replaced_q)
    else $error("single-byte value not emitted");
`endif

endmodule

[rtl/u8sd_step.sv]
// ----------------------------------------------------------------------------
// u8sd_step
// Combinational next-state and result logic for one input byte.
// ----------------------------------------------------------------------------
module u8sd_step (
  input  u8sd_pkg::seq_state_t               state_i,
  input  logic [u8sd_pkg::ByteW-1:0]         text_byte_i,
  input  logic                               last_byte_i,
  input  logic [u8sd_pkg::CodeW-1:0]         repl_i,
  output u8sd_pkg::seq_state_t               state_o,
  output u8sd_pkg::result_t                  result_o
);

  u8sd_pkg::seq_state_t upd;
  logic                 done;

  always_comb begin
    if (state_i.remaining == '0) begin
      upd.extra     = u8sd_pkg::lead_count(text_byte_i);
      upd.remaining = upd.extra;
      upd.acc       = {{(u8sd_pkg::CodeW-u8sd_pkg::ByteW){1'b0}}, text_byte_i};
    end else begin
      upd.extra     = state_i.extra;
      upd.remaining = state_i.remaining - 3'd1;
      upd.acc       = {state_i.acc[u8sd_pkg::CodeW-7:0], 6'b0}
                    + {{(u8sd_pkg::CodeW-u8sd_pkg::ByteW){1'b0}}, text_byte_i};
    end

    done = (upd.remaining == '0);

    result_o.valid    = done || last_byte_i;
    result_o.eot      = last_byte_i;
    result_o.replaced = !done;
    result_o.code     = done ? (upd.acc - u8sd_pkg::seq_offset(upd.extra)) : repl_i;

    // Any emitted result closes the sequence.
    if (result_o.valid) begin
      state_o = '0;
    end else begin
      state_o = upd;
    end
  end

endmodule
